/* hdl/tone_curve_pixel_mapper_defines.svh */
// Assertion macros shared by the tone curve pixel mapper RTL.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef TONE_CURVE_PIXEL_MAPPER_DEFINES_SVH
`define TONE_CURVE_PIXEL_MAPPER_DEFINES_SVH

// same-cycle implication
`define TCPM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TCPM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/tcpm_pkg.sv */
// Types and constants of the tone curve pixel mapper.
// Used by tcpm_curve and tone_curve_pixel_mapper; depends on nothing.
package tcpm_pkg;

   localparam int FRACTION_BITS  = 16;
   localparam int TABLE_ENTRIES  = 1024;
   localparam int CURVE_CHANNELS = 3;
   localparam int COLOR_CHANNELS = 3;

   localparam int SAMPLE_W  = 18;
   localparam int TSEL_W    = 2;
   localparam int TINDEX_W  = 10;
   localparam int VAL_W     = FRACTION_BITS + 1;
   localparam int IDX_W     = $clog2(TABLE_ENTRIES);
   localparam int BANK_W    = IDX_W - 1;
   localparam int BANK_DEPTH = TABLE_ENTRIES / 2;
   localparam int COUNT_W   = 3;

   localparam int ONE_INT   = 1 << FRACTION_BITS;
   localparam logic [VAL_W-1:0] UNIT = VAL_W'(ONE_INT);

   // identity ramp: ONE/(entries-1) per entry, carried as quotient and remainder
   localparam int RAMP_STEP = ONE_INT / (TABLE_ENTRIES - 1);
   localparam int RAMP_REM  = ONE_INT % (TABLE_ENTRIES - 1);

   // read-to-result latency of one curve lookup
   localparam int CURVE_LAT = 3;

   localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(3);
   localparam logic [COUNT_W-1:0] COUNT_MAX   = COUNT_W'(4);

   localparam logic [TSEL_W-1:0] SEL_MASTER = TSEL_W'(0);

   typedef enum logic [0:0] {
      OP_MAP   = 1'b0,
      OP_WRITE = 1'b1
   } op_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      logic [VAL_W-1:0] data;
   } tbl_wr_type;

endpackage

/* hdl/tcpm_curve.sv */
// One interpolated curve lookup: index, banked table read, blend multiply, sum.
// Table is split into even and odd entry banks so both neighbors read at once.
// Depends on tcpm_pkg.
module tcpm_curve
   import tcpm_pkg::*;
(
   input  logic             clock,
   input  logic             en,
   input  logic [VAL_W-1:0] x,
   input  tbl_wr_type       wr,
   output logic [VAL_W-1:0] y
);

   logic [VAL_W-1:0] even_mem_ff [BANK_DEPTH];
   logic [VAL_W-1:0] odd_mem_ff  [BANK_DEPTH];

   logic [VAL_W+IDX_W-1:0] scaled;
   logic [IDX_W-1:0]       idx;
   logic [IDX_W-1:0]       idx_up;
   logic [BANK_W-1:0]      even_addr;
   logic [BANK_W-1:0]      odd_addr;

   logic [VAL_W-1:0]         even_q_ff, odd_q_ff;
   logic                     lo_odd_ff;
   logic [FRACTION_BITS-1:0] frac_ff;

   logic [VAL_W-1:0]   lo, hi, wt_lo;
   logic [2*VAL_W-1:0] plo_in, plo_ff;
   logic [2*VAL_W-1:0] phi_in, phi_ff;
   logic [2*VAL_W:0]   sum;
   logic [VAL_W-1:0]   y_in, y_ff;

   always_comb begin
      scaled    = (VAL_W+IDX_W)'(x) * (VAL_W+IDX_W)'(TABLE_ENTRIES - 1);
      idx       = scaled[FRACTION_BITS +: IDX_W];
      idx_up    = idx + IDX_W'(1);
      // top entry has zero fraction, so the wrapped neighbor is weighted out
      even_addr = idx[0] ? idx_up[IDX_W-1:1] : idx[IDX_W-1:1];
      odd_addr  = idx[IDX_W-1:1];
   end

   always_ff @(posedge clock) begin
      if (wr.en && !wr.addr[0]) begin
         even_mem_ff[wr.addr[IDX_W-1:1]] <= wr.data;
      end
      if (en) begin
         even_q_ff <= even_mem_ff[even_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en && wr.addr[0]) begin
         odd_mem_ff[wr.addr[IDX_W-1:1]] <= wr.data;
      end
      if (en) begin
         odd_q_ff <= odd_mem_ff[odd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lo_odd_ff <= idx[0];
         frac_ff   <= scaled[FRACTION_BITS-1:0];
      end
   end

   always_comb begin
      lo     = lo_odd_ff ? odd_q_ff : even_q_ff;
      hi     = lo_odd_ff ? even_q_ff : odd_q_ff;
      wt_lo  = UNIT - VAL_W'(frac_ff);
      plo_in = (2*VAL_W)'(lo) * (2*VAL_W)'(wt_lo);
      phi_in = (2*VAL_W)'(hi) * (2*VAL_W)'(frac_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         plo_ff <= plo_in;
         phi_ff <= phi_in;
      end
   end

   always_comb begin
      sum  = (2*VAL_W+1)'(plo_ff) + (2*VAL_W+1)'(phi_ff);
      y_in = sum[FRACTION_BITS +: VAL_W];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         y_ff <= y_in;
      end
   end

   assign y = y_ff;

endmodule

/* hdl/tone_curve_pixel_mapper.sv */
// Tone curve pixel mapper. Takes one word per cycle unless stalled, a pixel to map
// or a curve table entry to write, and raises rsp_tvalid for a mapped pixel as it
// leaves the last stage; table writes return nothing. The pipeline is eight stages:
// input, clamp, then index/table read, blend multiply and sum once for the master
// curve and once for the channel curve, each a registered step; a held result stalls
// every stage together. After reset a clearing pass loads the identity ramp into
// all tables, during which req_tready stays low.
// Depends on tcpm_pkg, tcpm_curve and tone_curve_pixel_mapper_defines.svh.
`include "tone_curve_pixel_mapper_defines.svh"

module tone_curve_pixel_mapper
   import tcpm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // req_tdata, from bit 0: red_in[18], green_in[18], blue_in[18], alpha_in[18],
   // table_select[2], table_index[10], table_value[17], zero[3]
   input  logic [103:0] req_tdata,
   // req_tuser: operation[1]
   input  logic         req_tuser,
   input  logic         req_tvalid,
   output logic         req_tready,
   // rsp_tdata, from bit 0: red_out[17], green_out[17], blue_out[17],
   // alpha_out[18], zero[3]
   output logic [71:0]  rsp_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [COUNT_W-1:0] csr_data,
   input  logic         csr_valid,
   output logic         csr_ready
);

   localparam int STAGES     = 2 + 2 * CURVE_LAT;
   localparam int MST_STAGE  = 1;
   localparam int CHN_STAGE  = MST_STAGE + CURVE_LAT;
   localparam int LAST_STAGE = STAGES - 1;

   typedef struct packed {
      op_type                     op;
      logic [TSEL_W-1:0]          sel;
      logic [TINDEX_W-1:0]        idx;
      logic [VAL_W-1:0]           val;
      logic signed [SAMPLE_W-1:0] alpha;
   } meta_type;

   function automatic logic [VAL_W-1:0] clamp_unit(input logic signed [SAMPLE_W-1:0] s);
      logic [VAL_W-1:0] r;
      if (s < 0) begin
         r = '0;
      end else if (s > $signed(SAMPLE_W'(ONE_INT))) begin
         r = UNIT;
      end else begin
         r = VAL_W'(s);
      end
      return r;
   endfunction

   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_sat;

   logic               clear_busy_ff;
   logic [IDX_W-1:0]   clear_addr_ff;
   logic [VAL_W-1:0]   ramp_q_ff, ramp_q_in;
   logic [IDX_W-1:0]   ramp_r_ff, ramp_r_in;
   logic [IDX_W:0]     ramp_sum;

   logic               advance;
   logic               req_fire;
   logic [STAGES-1:0]  valid_ff;
   meta_type           meta_ff [STAGES];
   meta_type           meta_in;

   logic signed [SAMPLE_W-1:0] sample_ff [COLOR_CHANNELS];
   logic [VAL_W-1:0]           x_ff      [COLOR_CHANNELS];
   logic [VAL_W-1:0]           mst_y     [COLOR_CHANNELS];
   logic [VAL_W-1:0]           chn_y     [COLOR_CHANNELS];
   logic [VAL_W-1:0]           col_out   [COLOR_CHANNELS];
   logic signed [SAMPLE_W-1:0] alpha_out;

   // ---------------- configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_RESET;
      end else if (csr_valid) begin
         count_ff <= csr_data;
      end
   end

   assign count_sat = (count_ff > COUNT_MAX) ? COUNT_MAX : count_ff;

   // ---------------- identity ramp fill after reset
   always_comb begin
      ramp_sum = (IDX_W+1)'(ramp_r_ff) + (IDX_W+1)'(RAMP_REM);
      if (ramp_sum >= (IDX_W+1)'(TABLE_ENTRIES - 1)) begin
         ramp_r_in = IDX_W'(ramp_sum - (IDX_W+1)'(TABLE_ENTRIES - 1));
         ramp_q_in = ramp_q_ff + VAL_W'(RAMP_STEP + 1);
      end else begin
         ramp_r_in = IDX_W'(ramp_sum);
         ramp_q_in = ramp_q_ff + VAL_W'(RAMP_STEP);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_busy_ff <= 1'b1;
         clear_addr_ff <= '0;
         ramp_q_ff     <= '0;
         ramp_r_ff     <= '0;
      end else if (clear_busy_ff) begin
         clear_addr_ff <= clear_addr_ff + IDX_W'(1);
         ramp_q_ff     <= ramp_q_in;
         ramp_r_ff     <= ramp_r_in;
         if (clear_addr_ff == IDX_W'(TABLE_ENTRIES - 1)) begin
            clear_busy_ff <= 1'b0;
         end
      end
   end

   // ---------------- pipeline control
   assign rsp_tvalid = valid_ff[LAST_STAGE] && (meta_ff[LAST_STAGE].op == OP_MAP);
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance && !clear_busy_ff;
   assign req_fire   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[STAGES-2:0], req_fire};
      end
   end

   always_comb begin
      meta_in.op    = op_type'(req_tuser);
      meta_in.sel   = req_tdata[73:72];
      meta_in.idx   = req_tdata[83:74];
      meta_in.val   = (req_tdata[100:84] > UNIT) ? UNIT : req_tdata[100:84];
      meta_in.alpha = $signed(req_tdata[71:54]);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         meta_ff[0]   <= meta_in;
         sample_ff[0] <= $signed(req_tdata[17:0]);
         sample_ff[1] <= $signed(req_tdata[35:18]);
         sample_ff[2] <= $signed(req_tdata[53:36]);
         for (int k = 1; k < STAGES; k++) begin
            meta_ff[k] <= meta_ff[k-1];
         end
         for (int c = 0; c < COLOR_CHANNELS; c++) begin
            x_ff[c] <= clamp_unit(sample_ff[c]);
         end
      end
   end

   // ---------------- curve lanes
   for (genvar c = 0; c < COLOR_CHANNELS; c++) begin : g_lane
      localparam int TSEL = (c < CURVE_CHANNELS) ? c : CURVE_CHANNELS - 1;

      tbl_wr_type mst_wr, chn_wr;

      always_comb begin
         if (clear_busy_ff) begin
            mst_wr.en   = 1'b1;
            mst_wr.addr = clear_addr_ff;
            mst_wr.data = ramp_q_ff;
            chn_wr      = mst_wr;
         end else begin
            mst_wr.en   = advance && valid_ff[MST_STAGE]
                          && (meta_ff[MST_STAGE].op == OP_WRITE)
                          && (meta_ff[MST_STAGE].sel == SEL_MASTER);
            mst_wr.addr = IDX_W'(meta_ff[MST_STAGE].idx);
            mst_wr.data = meta_ff[MST_STAGE].val;
            chn_wr.en   = advance && valid_ff[CHN_STAGE]
                          && (meta_ff[CHN_STAGE].op == OP_WRITE)
                          && (meta_ff[CHN_STAGE].sel == TSEL_W'(TSEL + 1));
            chn_wr.addr = IDX_W'(meta_ff[CHN_STAGE].idx);
            chn_wr.data = meta_ff[CHN_STAGE].val;
         end
      end

      tcpm_curve u_master (
         .clock (clock),
         .en    (advance),
         .x     (x_ff[c]),
         .wr    (mst_wr),
         .y     (mst_y[c])
      );

      tcpm_curve u_channel (
         .clock (clock),
         .en    (advance),
         .x     (mst_y[c]),
         .wr    (chn_wr),
         .y     (chn_y[c])
      );

      assign col_out[c] = (count_sat > COUNT_W'(c)) ? chn_y[c] : '0;
   end

   assign alpha_out = (count_sat == COUNT_MAX) ? meta_ff[LAST_STAGE].alpha : '0;
   assign rsp_tdata = {3'b000, alpha_out, col_out[2], col_out[1], col_out[0]};

   // ---------------- assertions
   `TCPM_ASSERT_NOW(a_clear_pipe_empty, clock, reset, clear_busy_ff, valid_ff == '0,
      "pipeline holds words during table clear")
   `TCPM_ASSERT_NOW(a_ramp_top, clock, reset,
      clear_busy_ff && (clear_addr_ff == IDX_W'(TABLE_ENTRIES - 1)), ramp_q_ff == UNIT,
      "identity ramp does not end at one")
   `TCPM_ASSERT_NOW(a_ramp_rem, clock, reset, clear_busy_ff,
      ramp_r_ff < IDX_W'(TABLE_ENTRIES - 1), "ramp remainder out of range")
   `TCPM_ASSERT_NEXT(a_fill, clock, reset, req_fire, valid_ff[0],
      "accepted word missing from first stage")
   `TCPM_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_tvalid && !rsp_tready, $stable(valid_ff),
      "pipeline moved while result held")

endmodule

/* bench/tone_curve_pixel_mapper_tb.sv */
// Self-checking bench for tone_curve_pixel_mapper: pixel and table-write words are
// streamed in while a scoreboard class predicts each mapped pixel from its own
// copy of the curve tables. Depends on tcpm_pkg and the mapper RTL.
module tone_curve_pixel_mapper_tb
   import tcpm_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 16;
   localparam int PHASE_WORDS  = 90;

   // request word, lowest field last
   typedef struct packed {
      logic [2:0]         pad;
      logic [VAL_W-1:0]   value;
      logic [9:0]         index;
      logic [1:0]         sel;
      logic signed [17:0] alpha;
      logic signed [17:0] blue;
      logic signed [17:0] green;
      logic signed [17:0] red;
   } pixel_request_t;

   typedef struct packed {
      logic [2:0]         pad;
      logic signed [17:0] alpha;
      logic [VAL_W-1:0]   blue;
      logic [VAL_W-1:0]   green;
      logic [VAL_W-1:0]   red;
   } pixel_result_t;

   class tone_map_scoreboard;
      logic [VAL_W-1:0]   master_lut [TABLE_ENTRIES];
      logic [VAL_W-1:0]   channel_lut [CURVE_CHANNELS][TABLE_ENTRIES];
      logic [COUNT_W-1:0] count_reg;
      pixel_result_t      pending_pixels [$];
      int                 errors;

      function new();
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            master_lut[i] = VAL_W'((longint'(i) * ONE_INT) / (TABLE_ENTRIES - 1));
            for (int c = 0; c < CURVE_CHANNELS; c++)
               channel_lut[c][i] = master_lut[i];
         end
         count_reg = COUNT_RESET;
         errors = 0;
      endfunction

      function void set_count(logic [COUNT_W-1:0] v);
         count_reg = v;
      endfunction

      function int pending();
         return pending_pixels.size();
      endfunction

      // tbl 0 is the master curve, 1..3 the channel curves
      function longint entry(int tbl, longint idx);
         if (tbl == 0)
            return master_lut[idx];
         return channel_lut[tbl-1][idx];
      endfunction

      function longint curve_read(int tbl, longint x);
         longint scaled, idx, frac;
         scaled = x * (TABLE_ENTRIES - 1);
         idx = scaled >> FRACTION_BITS;
         frac = scaled & (ONE_INT - 1);
         if (idx >= TABLE_ENTRIES - 1)
            return entry(tbl, TABLE_ENTRIES - 1);
         return (entry(tbl, idx) * (ONE_INT - frac) + entry(tbl, idx + 1) * frac)
                >> FRACTION_BITS;
      endfunction

      function void note_word(op_type op, pixel_request_t w);
         logic [VAL_W-1:0]   val;
         logic [COUNT_W-1:0] eff;
         longint             samples [3];
         longint             y [3];
         pixel_result_t      want;
         if (op == OP_WRITE) begin
            val = (w.value > UNIT) ? UNIT : w.value;
            if (w.sel == SEL_MASTER)
               master_lut[w.index] = val;
            else
               channel_lut[w.sel - 1][w.index] = val;
            return;
         end
         eff = (count_reg > COUNT_MAX) ? COUNT_MAX : count_reg;
         samples = '{w.red, w.green, w.blue};
         for (int c = 0; c < COLOR_CHANNELS; c++) begin
            y[c] = 0;
            if (c < eff) begin
               // clamp to 0..1.0 before the master lookup
               if (samples[c] < 0)
                  samples[c] = 0;
               else if (samples[c] > ONE_INT)
                  samples[c] = ONE_INT;
               y[c] = curve_read(c + 1, curve_read(0, samples[c]));
            end
         end
         want.pad   = '0;
         want.red   = VAL_W'(y[0]);
         want.green = VAL_W'(y[1]);
         want.blue  = VAL_W'(y[2]);
         want.alpha = (eff >= COUNT_MAX) ? w.alpha : '0;
         pending_pixels.push_back(want);
      endfunction

      function void check_pixel(pixel_result_t got);
         pixel_result_t want;
         longint        want_f [4];
         longint        got_f [4];
         string         names [4];
         if (pending_pixels.size() == 0) begin
            errors++;
            $display("%0t: unexpected pixel word %h", $time, got);
            return;
         end
         want = pending_pixels.pop_front();
         names = '{"red", "green", "blue", "alpha"};
         want_f = '{want.red, want.green, want.blue, want.alpha};
         got_f = '{got.red, got.green, got.blue, got.alpha};
         for (int i = 0; i < 4; i++) begin
            if (want_f[i] != got_f[i] || got.pad != '0) begin
               errors++;
               $display("%0t: %s expected %0d actual %0d (pad %b)", $time, names[i],
                        want_f[i], got_f[i], got.pad);
            end
         end
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic [103:0]        req_tdata = '0;
   logic                req_tuser = 1'b0;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [71:0]         rsp_tdata;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [COUNT_W-1:0]  csr_data = '0;
   logic                csr_valid = 1'b0;
   logic                csr_ready;

   tone_map_scoreboard  board = new();
   bit                  idle_on = 1'b1;
   int                  last_index = 0;
   int unsigned         cycle_count = 0;

   tone_curve_pixel_mapper u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_data   (csr_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // result side: random stall after each accepted word while idle_on is set
   initial begin : rsp_side
      int hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
            board.check_pixel(pixel_result_t'(rsp_tdata));
            hold = idle_on ? $urandom_range(0, 3) : 0;
         end
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            hold--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // valid is left high after acceptance so back-to-back words need no toggle
   task automatic send_word(input op_type op, input pixel_request_t w);
      int gap;
      gap = idle_on ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= w;
      req_tuser  <= op;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (req_tready !== 1'b1);
      board.note_word(op, w);
   endtask

   task automatic send_map(input int r, input int g, input int b, input int a);
      pixel_request_t w;
      w = '0;
      w.red   = 18'(r);
      w.green = 18'(g);
      w.blue  = 18'(b);
      w.alpha = 18'(a);
      w.sel   = 2'($urandom);
      w.index = 10'($urandom);
      w.value = VAL_W'($urandom);
      send_word(OP_MAP, w);
   endtask

   task automatic send_entry(input int tsel, input int idx, input int val);
      pixel_request_t w;
      w = '0;
      w.red   = 18'($urandom);
      w.green = 18'($urandom);
      w.blue  = 18'($urandom);
      w.alpha = 18'($urandom);
      w.sel   = 2'(tsel);
      w.index = 10'(idx);
      w.value = VAL_W'(val);
      send_word(OP_WRITE, w);
      last_index = idx;
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_count(input logic [COUNT_W-1:0] v);
      csr_data  <= v;
      csr_valid <= 1'b1;
      do @(posedge clock); while (csr_ready !== 1'b1);
      board.set_count(v);
      csr_valid <= 1'b0;
   endtask

   function automatic int pick_sample();
      int corners [8];
      int near;
      corners = '{-131072, -1, 0, 1, 65535, 65536, 65537, 131071};
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return $urandom_range(0, ONE_INT);
         5, 6: begin
            // land next to the most recently written entry
            near = (last_index * ONE_INT) / (TABLE_ENTRIES - 1) + $urandom_range(0, 128) - 64;
            return (near < 0) ? 0 : near;
         end
         7: return corners[$urandom_range(0, 7)];
         default: return int'(18'($urandom)) - (($urandom & 1) ? 0 : 131072);
      endcase
   endfunction

   task automatic send_random_word();
      int idx;
      int val;
      if ($urandom_range(0, 4) == 0) begin
         idx = ($urandom & 1) ? $urandom_range(0, TABLE_ENTRIES - 1)
                              : (last_index + 1) % TABLE_ENTRIES;
         val = ($urandom_range(0, 3) == 0) ? int'(VAL_W'($urandom))
                                           : $urandom_range(0, ONE_INT);
         send_entry($urandom_range(0, 3), idx, val);
      end else begin
         send_map(pick_sample(), pick_sample(), pick_sample(), int'($urandom));
      end
   endtask

   initial begin : stimulus
      logic [COUNT_W-1:0] counts [12];
      counts = '{3'd3, 3'd4, 3'd1, 3'd0, 3'd2, 3'd7, 3'd5, 3'd6, 3'd4, 3'd3, 3'd2, 3'd1};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: corners of every field, saturating writes, last-entry reads
      write_count(COUNT_MAX);
      send_map(0, 0, 0, 0);
      send_map(ONE_INT, ONE_INT, ONE_INT, 131071);
      send_map(-131072, -131072, -131072, -131072);
      send_map(131071, 131071, 131071, -1);
      send_map(ONE_INT - 1, 1, 32768, 0);
      send_entry(0, 1023, 131071);
      send_entry(1, 0, ONE_INT);
      send_entry(2, 512, 0);
      send_entry(3, 1023, ONE_INT + 1);
      send_map(ONE_INT, 0, ONE_INT, 12345);
      send_entry(0, 0, ONE_INT);
      send_map(0, 0, 0, 77);
      send_map(32800, 32768, 32832, -77);
      send_entry(3, 1, 0);
      send_map(64, 64, 65472, 1);

      for (int p = 0; p < 12; p++) begin
         drain_results();
         idle_on = (p % 3 != 2);
         write_count(counts[p]);
         repeat (PHASE_WORDS) send_random_word();
      end

      drain_results();
      if (board.errors == 0 && board.pending() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

/* sim.f */
+incdir+hdl
hdl/tcpm_pkg.sv
hdl/tcpm_curve.sv
hdl/tone_curve_pixel_mapper.sv
bench/tone_curve_pixel_mapper_tb.sv
